/* design/bpv_pkg.sv */
`default_nettype none

package bpv_pkg;

   // Fixed field widths of the request and response items
   localparam int BYTE_WIDTH     = 8;
   localparam int ERROR_WIDTH    = 4;
   localparam int INDEX_WIDTH    = 4;
   localparam int SHADE_OUT_W    = 2;
   localparam int NAME_LEN_WIDTH = 4;
   localparam int NAME_LOW_W     = 64;
   localparam int NAME_HIGH_W    = 32;

   // Payload layout
   localparam int HEADER_BYTES   = 8;
   localparam int MAX_NAME_BYTES = 12;
   localparam int COUNT_WIDTH    = 5;
   localparam int HEADER_WIDTH   = 16;
   localparam int FIELD_WIDTH    = 8;

   // Printable ASCII range
   localparam logic [7:0] CHAR_LO = 8'h20;
   localparam logic [7:0] CHAR_HI = 8'h7E;

   // Index reduction: q = (v * RECIP) >> 11 is the quotient or one below it
   localparam int RECIP_SHIFT = 11;
   localparam int NICK_MOD    = 10;
   localparam int NICK_RECIP  = 204;
   localparam int OUTFIT_MOD  = 14;
   localparam int OUTFIT_RECIP = 146;

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      CSR_MAGIC   = 3'd0,
      CSR_VERSION = 3'd1,
      CSR_NICK    = 3'd2,
      CSR_OUTFIT  = 3'd3,
      CSR_SHADE   = 3'd4,
      CSR_CUSTOM  = 3'd5
   } csr_index_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK          = 4'd0,
      ERR_LENGTH      = 4'd1,
      ERR_MAGIC       = 4'd2,
      ERR_VERSION     = 4'd3,
      ERR_FLAGS       = 4'd4,
      ERR_CUSTOM      = 4'd5,
      ERR_UNPRINTABLE = 4'd6,
      ERR_EMPTY       = 4'd7,
      ERR_PADDING     = 4'd8
   } error_code_type;

   // Remainder of an 8-bit value by a small constant, via reciprocal
   function automatic logic [7:0] reduce_mod(input logic [7:0] value,
                                             input logic [7:0] modulus,
                                             input logic [7:0] recip);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [8:0]  back;
      logic [8:0]  rem;
      prod = value * recip;
      quot = prod[15:RECIP_SHIFT];
      back = 9'(quot * modulus);
      rem  = {1'b0, value} - back;
      if (rem >= {1'b0, modulus}) begin
         rem = rem - {1'b0, modulus};
      end
      return rem[7:0];
   endfunction

endpackage

`default_nettype wire

/* design/bpv_if.sv */
`default_nettype none

interface bpv_req_if;
   logic                             valid;
   logic                             ready;
   logic [bpv_pkg::BYTE_WIDTH-1:0]   payload_byte;
   logic                             final_byte;

   modport source (output valid, output payload_byte, output final_byte, input ready);
   modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface bpv_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 accepted;
   bpv_pkg::error_code_type              error_code;
   logic [bpv_pkg::INDEX_WIDTH-1:0]      nick_index;
   logic [bpv_pkg::INDEX_WIDTH-1:0]      outfit_index;
   logic [bpv_pkg::SHADE_OUT_W-1:0]      shade_index;
   logic                                 has_custom_name;
   logic [bpv_pkg::NAME_LEN_WIDTH-1:0]   name_length;
   logic [bpv_pkg::NAME_LOW_W-1:0]       name_low;
   logic [bpv_pkg::NAME_HIGH_W-1:0]      name_high;

   modport source (output valid, output accepted, output error_code, output nick_index,
                   output outfit_index, output shade_index, output has_custom_name,
                   output name_length, output name_low, output name_high, input ready);
   modport sink   (input valid, input accepted, input error_code, input nick_index,
                   input outfit_index, input shade_index, input has_custom_name,
                   input name_length, input name_low, input name_high, output ready);
endinterface

`default_nettype wire

/* design/beacon_payload_validator.sv */
`default_nettype none

// Channel   Dir  Handshake      Carries
// req_if    in   valid/ready    payload_byte, final_byte (one request per payload byte)
// rsp_if    out  valid/ready    verdict, reduced indices and name (one per final byte)
// csr_*     in   APB write/read magic word, version, four header bit positions
//
// Throughput is one request per cycle while no final byte waits on a stalled
// response, set by the single stage of per-byte logic between the request
// register and the response register; a final byte's verdict shows on rsp_if.
// Reset (synchronous, active high) empties both registers, clears the
// per-payload state and loads the register defaults; the name store is not cleared.
// A stalled response holds only final bytes; non-final bytes keep flowing into
// the payload state while the response waits.

module beacon_payload_validator #(
   parameter int NAME_BYTES   = 12,
   parameter int NICK_WIDTH   = 4,
   parameter int OUTFIT_WIDTH = 4,
   parameter int SHADE_WIDTH  = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bpv_req_if.sink                                   req_if,
   bpv_rsp_if.source                                 rsp_if,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bpv_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [bpv_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [bpv_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   localparam int CW    = bpv_pkg::COUNT_WIDTH;
   localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam logic [CW-1:0] SHORT_LEN = CW'(bpv_pkg::HEADER_BYTES);
   localparam logic [CW-1:0] LONG_LEN  = CW'(bpv_pkg::HEADER_BYTES + NAME_BYTES);
   localparam logic [CW-1:0] COUNT_CAP = CW'(bpv_pkg::HEADER_BYTES + NAME_BYTES + 1);
   localparam logic [7:0] NICK_MASK   = 8'((1 << NICK_WIDTH) - 1);
   localparam logic [7:0] OUTFIT_MASK = 8'((1 << OUTFIT_WIDTH) - 1);
   localparam logic [7:0] SHADE_MASK  = 8'((1 << SHADE_WIDTH) - 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [31:0] magic_ff;
   logic [7:0]  version_ff;
   logic [3:0]  nick_pos_ff;
   logic [3:0]  outfit_pos_ff;
   logic [3:0]  shade_pos_ff;
   logic [3:0]  custom_pos_ff;
   logic        csr_write;
   bpv_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bpv_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff      <= '0;
         version_ff    <= 8'd1;
         nick_pos_ff   <= 4'd0;
         outfit_pos_ff <= 4'd4;
         shade_pos_ff  <= 4'd8;
         custom_pos_ff <= 4'd15;
      end else if (csr_write) begin
         // Writes past the last register are dropped
         unique case (csr_index)
            bpv_pkg::CSR_MAGIC:   magic_ff      <= csr_pwdata;
            bpv_pkg::CSR_VERSION: version_ff    <= csr_pwdata[7:0];
            bpv_pkg::CSR_NICK:    nick_pos_ff   <= csr_pwdata[3:0];
            bpv_pkg::CSR_OUTFIT:  outfit_pos_ff <= csr_pwdata[3:0];
            bpv_pkg::CSR_SHADE:   shade_pos_ff  <= csr_pwdata[3:0];
            bpv_pkg::CSR_CUSTOM:  custom_pos_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bpv_pkg::CSR_MAGIC:   csr_prdata = magic_ff;
         bpv_pkg::CSR_VERSION: csr_prdata = {24'd0, version_ff};
         bpv_pkg::CSR_NICK:    csr_prdata = {28'd0, nick_pos_ff};
         bpv_pkg::CSR_OUTFIT:  csr_prdata = {28'd0, outfit_pos_ff};
         bpv_pkg::CSR_SHADE:   csr_prdata = {28'd0, shade_pos_ff};
         bpv_pkg::CSR_CUSTOM:  csr_prdata = {28'd0, custom_pos_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Request register and flow control
   // ---------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_final_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_advance;
   logic       s1_move;
   logic       req_take;

   // Only a final byte needs room in the response register
   assign out_advance  = !rsp_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && (!s1_final_ff || out_advance);
   assign req_if.ready = !reset && (!s1_valid_ff || s1_move);
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_if.payload_byte;
         s1_final_ff <= req_if.final_byte;
      end
   end

   // ---------------------------------------------------------------
   // Per-payload state
   // ---------------------------------------------------------------
   logic [CW-1:0]             count_ff, count_in;
   logic [15:0]               hdr_ff, hdr_in;
   bpv_pkg::error_code_type   fault_ff, fault_in;
   logic [3:0]                chars_ff, chars_in;
   logic                      term_ff, term_in;
   logic                      bad_char_ff, bad_char_in;
   logic                      bad_pad_ff, bad_pad_in;
   logic [7:0]                name_store [NAME_BYTES];

   logic [CW-1:0]   pos;
   logic [CW-1:0]   name_off;
   logic [IDX_W-1:0] name_idx;
   logic            name_write;
   logic [7:0]      magic_byte;
   logic            printable;

   assign pos        = count_ff;
   assign name_off   = pos - SHORT_LEN;
   assign name_idx   = name_off[IDX_W-1:0];
   assign name_write = s1_move && (pos >= SHORT_LEN) && (pos < LONG_LEN);
   assign magic_byte = 8'(magic_ff >> {pos[1:0], 3'b000});
   assign printable  = (s1_byte_ff >= bpv_pkg::CHAR_LO) && (s1_byte_ff <= bpv_pkg::CHAR_HI);

   // Apply the current byte to the header checks and name trackers
   always_comb begin
      hdr_in      = hdr_ff;
      fault_in    = fault_ff;
      chars_in    = chars_ff;
      term_in     = term_ff;
      bad_char_in = bad_char_ff;
      bad_pad_in  = bad_pad_ff;
      priority if (pos < 5'd4) begin
         if (fault_ff == bpv_pkg::ERR_OK && s1_byte_ff != magic_byte) begin
            fault_in = bpv_pkg::ERR_MAGIC;
         end
      end else if (pos == 5'd4) begin
         if (fault_ff == bpv_pkg::ERR_OK && s1_byte_ff != version_ff) begin
            fault_in = bpv_pkg::ERR_VERSION;
         end
      end else if (pos == 5'd5) begin
         hdr_in[7:0] = s1_byte_ff;
      end else if (pos == 5'd6) begin
         hdr_in[15:8] = s1_byte_ff;
      end else if (pos == 5'd7) begin
         if (fault_ff == bpv_pkg::ERR_OK && s1_byte_ff != 8'd0) begin
            fault_in = bpv_pkg::ERR_FLAGS;
         end
      end else if (pos < LONG_LEN) begin
         if (!term_ff) begin
            priority if (s1_byte_ff == 8'd0) begin
               term_in = 1'b1;
            end else if (printable && !bad_char_ff) begin
               chars_in = chars_ff + 4'd1;
            end else begin
               bad_char_in = 1'b1;
            end
         end else if (s1_byte_ff != 8'd0) begin
            bad_pad_in = 1'b1;
         end
      end else begin
         // Bytes past the longest payload are ignored
      end
   end

   always_comb begin
      count_in = count_ff;
      if (count_ff < COUNT_CAP) begin
         count_in = count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         hdr_ff      <= '0;
         fault_ff    <= bpv_pkg::ERR_OK;
         chars_ff    <= '0;
         term_ff     <= 1'b0;
         bad_char_ff <= 1'b0;
         bad_pad_ff  <= 1'b0;
      end else if (s1_move) begin
         if (s1_final_ff) begin
            // Drop all per-payload state after the verdict
            count_ff    <= '0;
            hdr_ff      <= '0;
            fault_ff    <= bpv_pkg::ERR_OK;
            chars_ff    <= '0;
            term_ff     <= 1'b0;
            bad_char_ff <= 1'b0;
            bad_pad_ff  <= 1'b0;
         end else begin
            count_ff    <= count_in;
            hdr_ff      <= hdr_in;
            fault_ff    <= fault_in;
            chars_ff    <= chars_in;
            term_ff     <= term_in;
            bad_char_ff <= bad_char_in;
            bad_pad_ff  <= bad_pad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (name_write) begin
         name_store[name_idx] <= s1_byte_ff;
      end
   end

   // ---------------------------------------------------------------
   // Verdict
   // ---------------------------------------------------------------
   logic [CW-1:0]           len;
   logic                    custom;
   logic                    is_long;
   bpv_pkg::error_code_type err;
   logic [7:0]              nick_raw, outfit_raw, shade_raw;
   logic [7:0]              nick_red, outfit_red;
   logic [7:0]              name_bytes [bpv_pkg::MAX_NAME_BYTES];
   logic [63:0]             name_low_w;
   logic [31:0]             name_high_w;

   assign len     = pos + 5'd1;
   assign is_long = (len == LONG_LEN);
   assign custom  = hdr_in[custom_pos_ff];

   always_comb begin
      priority if (len != SHORT_LEN && !is_long) begin
         err = bpv_pkg::ERR_LENGTH;
      end else if (fault_in != bpv_pkg::ERR_OK) begin
         err = fault_in;
      end else if (custom != is_long) begin
         err = bpv_pkg::ERR_CUSTOM;
      end else if (custom && bad_char_in) begin
         err = bpv_pkg::ERR_UNPRINTABLE;
      end else if (custom && chars_in == 4'd0) begin
         err = bpv_pkg::ERR_EMPTY;
      end else if (custom && bad_pad_in) begin
         err = bpv_pkg::ERR_PADDING;
      end else begin
         err = bpv_pkg::ERR_OK;
      end
   end

   assign nick_raw   = 8'(hdr_in >> nick_pos_ff) & NICK_MASK;
   assign outfit_raw = 8'(hdr_in >> outfit_pos_ff) & OUTFIT_MASK;
   assign shade_raw  = 8'(hdr_in >> shade_pos_ff) & SHADE_MASK;
   assign nick_red   = bpv_pkg::reduce_mod(nick_raw, 8'(bpv_pkg::NICK_MOD),
                                           8'(bpv_pkg::NICK_RECIP));
   assign outfit_red = bpv_pkg::reduce_mod(outfit_raw, 8'(bpv_pkg::OUTFIT_MOD),
                                           8'(bpv_pkg::OUTFIT_RECIP));

   // Name as it stands after this byte, zero past the counted characters
   always_comb begin
      for (int i = 0; i < bpv_pkg::MAX_NAME_BYTES; i++) begin
         name_bytes[i] = 8'd0;
      end
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (4'(i) < chars_in) begin
            if (name_write && name_idx == IDX_W'(i)) begin
               name_bytes[i] = s1_byte_ff;
            end else begin
               name_bytes[i] = name_store[i];
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         name_low_w[8*i +: 8] = name_bytes[i];
      end
      for (int i = 0; i < 4; i++) begin
         name_high_w[8*i +: 8] = name_bytes[8 + i];
      end
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic                    rsp_load;
   logic                    acc_ff;
   bpv_pkg::error_code_type err_ff;
   logic [3:0]              nick_ff, outfit_ff;
   logic [1:0]              shade_ff;
   logic                    custom_ff;
   logic [3:0]              name_count_ff;
   logic [63:0]             name_low_ff;
   logic [31:0]             name_high_ff;
   logic                    ok;

   assign rsp_load = s1_move && s1_final_ff;
   assign ok       = (err == bpv_pkg::ERR_OK);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Rejected payloads report only the error code
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         acc_ff        <= ok;
         err_ff        <= err;
         nick_ff       <= ok ? nick_red[3:0] : 4'd0;
         outfit_ff     <= ok ? outfit_red[3:0] : 4'd0;
         shade_ff      <= ok ? shade_raw[1:0] : 2'd0;
         custom_ff     <= ok && custom;
         name_count_ff <= (ok && custom) ? chars_in : 4'd0;
         name_low_ff   <= (ok && custom) ? name_low_w : 64'd0;
         name_high_ff  <= (ok && custom) ? name_high_w : 32'd0;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.accepted        = acc_ff;
   assign rsp_if.error_code      = err_ff;
   assign rsp_if.nick_index      = nick_ff;
   assign rsp_if.outfit_index    = outfit_ff;
   assign rsp_if.shade_index     = shade_ff;
   assign rsp_if.has_custom_name = custom_ff;
   assign rsp_if.name_length     = name_count_ff;
   assign rsp_if.name_low        = name_low_ff;
   assign rsp_if.name_high       = name_high_ff;

endmodule

`default_nettype wire
